@@ sv/svm_pkg.sv @@
package svm_pkg;

    localparam int PROGRAM_DEPTH  = 256;
    localparam int STACK_DEPTH    = 256;
    localparam int REGISTER_COUNT = 8;
    localparam int SP_INDEX       = 0;
    localparam int IP_INDEX       = 1;

    localparam int WORD_W = 32;
    localparam int PAW    = $clog2(PROGRAM_DEPTH);
    localparam int SAW    = $clog2(STACK_DEPTH);
    localparam int RAW    = $clog2(REGISTER_COUNT);

    typedef logic [WORD_W-1:0] t_word;

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;

    localparam t_word OP_HLT = 32'd0;
    localparam t_word OP_PSH = 32'd1;
    localparam t_word OP_POP = 32'd2;
    localparam t_word OP_SET = 32'd3;
    localparam t_word OP_MOV = 32'd4;
    localparam t_word OP_LOD = 32'd5;
    localparam t_word OP_STR = 32'd6;
    localparam t_word OP_ADD = 32'd7;
    localparam t_word OP_SUB = 32'd8;
    localparam t_word OP_MUL = 32'd9;
    localparam t_word OP_DIV = 32'd10;
    localparam t_word OP_MOD = 32'd11;
    localparam t_word OP_CMP = 32'd12;
    localparam t_word OP_JMP = 32'd13;
    localparam t_word OP_JEQ = 32'd14;
    localparam t_word OP_JNE = 32'd15;
    localparam t_word OP_JGT = 32'd16;
    localparam t_word OP_JLT = 32'd17;
    localparam t_word OP_PRN = 32'd18;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_HALT      = 4'd1;
    localparam logic [3:0] ST_IP_BOUNDS = 4'd2;
    localparam logic [3:0] ST_UNDERFLOW = 4'd3;
    localparam logic [3:0] ST_OVERFLOW  = 4'd4;
    localparam logic [3:0] ST_BAD_REG   = 4'd5;
    localparam logic [3:0] ST_BAD_JUMP  = 4'd6;
    localparam logic [3:0] ST_DIV_ZERO  = 4'd7;
    localparam logic [3:0] ST_BAD_OP    = 4'd8;

endpackage

@@ sv/svm_ram.sv @@
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/svm_div.sv @@
module svm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  svm_pkg::t_word       i_dividend,
    input  svm_pkg::t_word       i_divisor,
    output logic                 o_done,
    output svm_pkg::t_word       o_quotient,
    output svm_pkg::t_word       o_remainder
);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [4:0]     r_cnt, n_cnt;
    svm_pkg::t_word r_rem, n_rem;
    svm_pkg::t_word r_quo, n_quo;
    svm_pkg::t_word r_den, n_den;
    logic           r_qneg, n_qneg;
    logic           r_rneg, n_rneg;
    logic [32:0]    shifted;
    logic [32:0]    diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_qneg  = r_qneg;
        n_rneg  = r_rneg;
        shifted = {r_rem, r_quo[31]};
        diff    = shifted - {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = '0;
            n_quo  = i_dividend[31] ? (~i_dividend + 32'd1) : i_dividend;
            n_den  = i_divisor[31] ? (~i_divisor + 32'd1) : i_divisor;
            n_qneg = i_dividend[31] ^ i_divisor[31];
            n_rneg = i_dividend[31];
        end else if (r_busy) begin
            if (!diff[32]) begin
                n_rem = diff[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = shifted[31:0];
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_qneg ? (~r_quo + 32'd1) : r_quo;
    assign o_remainder = r_rneg ? (~r_rem + 32'd1) : r_rem;

endmodule

@@ sv/stack_vm_instruction_step.sv @@
// init, load, no-op or step while stopped set the done flag, which then loads the output register
// each fetched word takes fetch, fetch-wait, execute; each stack read takes read, wait, execute
// div and mod then run in the shared 1-bit-per-cycle divider
// one item at a time; a new transfer waits for the done flag to clear and the output to be free
// reset clears flags, run state, program-valid bits (program reads 0), registers but SP (all 1s)
module stack_vm_instruction_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_address,
    input  logic [31:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_print_valid,
    output logic        o_print_kind,
    output logic [31:0] o_print_value,
    output logic        o_running,
    output logic [3:0]  o_status,
    output logic [2:0]  o_compare_flags
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_FWAIT = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_SRD   = 7'b0010000,
        S_SWAIT = 7'b0100000,
        S_DIV   = 7'b1000000
    } t_state;

    localparam logic signed [31:0] SD_S = 32'(svm_pkg::STACK_DEPTH);
    localparam logic signed [31:0] PD_S = 32'(svm_pkg::PROGRAM_DEPTH);
    localparam svm_pkg::t_word RC_W = 32'(svm_pkg::REGISTER_COUNT);
    localparam svm_pkg::t_word PD_W = 32'(svm_pkg::PROGRAM_DEPTH);

    t_state r_state, n_state;
    logic   r_done, n_done;
    svm_pkg::t_word r_op, n_op, r_x, n_x, r_y, n_y, r_a, n_a, r_b, n_b;
    logic [1:0] r_nf, n_nf, r_np, n_np;
    svm_pkg::t_word r_rf [svm_pkg::REGISTER_COUNT];
    svm_pkg::t_word n_rf [svm_pkg::REGISTER_COUNT];
    logic r_feq, n_feq, r_fgt, n_fgt, r_flt, n_flt, r_running, n_running;
    logic [3:0] r_status, n_status;
    logic r_pv, n_pv, r_pk, n_pk;
    svm_pkg::t_word r_pval, n_pval;
    logic [svm_pkg::PROGRAM_DEPTH-1:0] r_pvld, n_pvld;
    logic [svm_pkg::PAW-1:0] r_paddr, n_paddr;

    logic r_ov;
    logic r_o_pv, r_o_pk, r_o_run;
    svm_pkg::t_word r_o_pval;
    logic [3:0] r_o_status;
    logic [2:0] r_o_flags;

    logic p_we;
    logic [svm_pkg::PAW-1:0] p_waddr, p_raddr;
    svm_pkg::t_word p_wdata, p_rdata;
    logic s_we;
    logic [svm_pkg::SAW-1:0] s_waddr, s_raddr;
    svm_pkg::t_word s_wdata, s_rdata;

    logic div_start, div_done;
    svm_pkg::t_word div_q, div_r;

    logic signed [31:0] sp_s, ip_s, sp1;
    svm_pkg::t_word word_in, push_val, prod;
    logic push_en, bad_ip;
    logic [svm_pkg::RAW-1:0] xi, yi;
    logic take;

    svm_ram #(.WIDTH(svm_pkg::WORD_W), .DEPTH(svm_pkg::PROGRAM_DEPTH)) u_prog (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    svm_ram #(.WIDTH(svm_pkg::WORD_W), .DEPTH(svm_pkg::STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    svm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_b), .i_divisor(r_a), .o_done(div_done),
        .o_quotient(div_q), .o_remainder(div_r)
    );

    function automatic logic [3:0] first_err(input logic [3:0] cur, input logic [3:0] code);
        first_err = (cur == svm_pkg::ST_OK) ? code : cur;
    endfunction

    assign sp_s   = $signed(r_rf[svm_pkg::SP_INDEX]);
    assign ip_s   = $signed(r_rf[svm_pkg::IP_INDEX]);
    assign bad_ip = (ip_s < 0) || (ip_s >= PD_S);
    assign xi     = r_x[svm_pkg::RAW-1:0];
    assign yi     = r_y[svm_pkg::RAW-1:0];
    assign prod   = r_b * r_a;

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_op      = r_op;
        n_x       = r_x;
        n_y       = r_y;
        n_a       = r_a;
        n_b       = r_b;
        n_nf      = r_nf;
        n_np      = r_np;
        n_rf      = r_rf;
        n_feq     = r_feq;
        n_fgt     = r_fgt;
        n_flt     = r_flt;
        n_running = r_running;
        n_status  = r_status;
        n_pv      = r_pv;
        n_pk      = r_pk;
        n_pval    = r_pval;
        n_pvld    = r_pvld;
        n_paddr   = r_paddr;
        p_we      = 1'b0;
        p_waddr   = i_address[svm_pkg::PAW-1:0];
        p_wdata   = i_data;
        p_raddr   = r_rf[svm_pkg::IP_INDEX][svm_pkg::PAW-1:0];
        s_we      = 1'b0;
        s_waddr   = '0;
        s_wdata   = '0;
        s_raddr   = r_rf[svm_pkg::SP_INDEX][svm_pkg::SAW-1:0];
        div_start = 1'b0;
        push_en   = 1'b0;
        push_val  = '0;
        word_in   = p_rdata;
        take      = 1'b0;
        sp1       = sp_s + 32'sd1;

        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_status = svm_pkg::ST_OK;
                    n_pv     = 1'b0;
                    n_pk     = 1'b0;
                    n_pval   = '0;
                    n_nf     = 2'd0;
                    n_np     = 2'd0;
                    n_done   = 1'b1;
                    if (i_command == svm_pkg::CMD_INIT) begin
                        for (int i = 0; i < svm_pkg::REGISTER_COUNT; i++) begin
                            n_rf[i] = '0;
                        end
                        n_rf[svm_pkg::SP_INDEX] = '1;
                        n_feq     = 1'b0;
                        n_fgt     = 1'b0;
                        n_flt     = 1'b0;
                        n_running = 1'b1;
                    end else if (i_command == svm_pkg::CMD_LOAD) begin
                        if (32'(i_address) < PD_W) begin
                            p_we = 1'b1;
                            n_pvld[i_address[svm_pkg::PAW-1:0]] = 1'b1;
                        end
                    end else if (i_command == svm_pkg::CMD_STEP && r_running) begin
                        n_done  = 1'b0;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                if (bad_ip) begin
                    n_running = 1'b0;
                    n_status  = first_err(r_status, svm_pkg::ST_IP_BOUNDS);
                    case (r_nf)
                        2'd0:    n_op = '0;
                        2'd1:    n_x  = '0;
                        default: n_y  = '0;
                    endcase
                    n_nf    = r_nf + 2'd1;
                    n_state = S_EXEC;
                end else begin
                    n_paddr = r_rf[svm_pkg::IP_INDEX][svm_pkg::PAW-1:0];
                    n_rf[svm_pkg::IP_INDEX] = r_rf[svm_pkg::IP_INDEX] + 32'd1;
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: begin
                word_in = r_pvld[r_paddr] ? p_rdata : '0;
                case (r_nf)
                    2'd0:    n_op = word_in;
                    2'd1:    n_x  = word_in;
                    default: n_y  = word_in;
                endcase
                n_nf    = r_nf + 2'd1;
                n_state = S_EXEC;
            end
            S_SRD: begin
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (r_np == 2'd0) begin
                    n_a = s_rdata;
                end else begin
                    n_b = s_rdata;
                end
                n_np = r_np + 2'd1;
                if (r_op != svm_pkg::OP_PRN) begin
                    n_rf[svm_pkg::SP_INDEX] = r_rf[svm_pkg::SP_INDEX] - 32'd1;
                end
                n_state = S_EXEC;
            end
            S_DIV: begin
                if (div_done) begin
                    push_en  = 1'b1;
                    push_val = (r_op == svm_pkg::OP_DIV) ? div_q : div_r;
                    n_done   = 1'b1;
                end
            end
            S_EXEC: begin
                n_done = 1'b1;
                case (r_op)
                    svm_pkg::OP_HLT: begin
                        n_running = 1'b0;
                        n_status  = first_err(r_status, svm_pkg::ST_HALT);
                    end
                    svm_pkg::OP_PSH: begin
                        if (r_nf == 2'd1) begin
                            if (sp_s >= SD_S - 32'sd1) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_OVERFLOW);
                            end else if (sp_s < -32'sd1) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_UNDERFLOW);
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_FETCH;
                            end
                        end else begin
                            push_en  = 1'b1;
                            push_val = r_x;
                        end
                    end
                    svm_pkg::OP_POP, svm_pkg::OP_PRN: begin
                        if (r_np == 2'd0) begin
                            if (sp_s < 32'sd0) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_UNDERFLOW);
                            end else if (sp_s >= SD_S) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_OVERFLOW);
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SRD;
                            end
                        end else begin
                            n_pv   = 1'b1;
                            n_pk   = (r_op == svm_pkg::OP_PRN);
                            n_pval = r_a;
                        end
                    end
                    svm_pkg::OP_SET, svm_pkg::OP_MOV: begin
                        if (r_nf != 2'd3) begin
                            n_done  = 1'b0;
                            n_state = S_FETCH;
                        end else if (r_x >= RC_W) begin
                            n_running = 1'b0;
                            n_status  = first_err(r_status, svm_pkg::ST_BAD_REG);
                        end else if (r_op == svm_pkg::OP_SET) begin
                            n_rf[xi] = r_y;
                        end else if (r_y >= RC_W) begin
                            n_running = 1'b0;
                            n_status  = first_err(r_status, svm_pkg::ST_BAD_REG);
                        end else begin
                            n_rf[xi] = r_rf[yi];
                        end
                    end
                    svm_pkg::OP_LOD, svm_pkg::OP_STR: begin
                        if (r_nf == 2'd1) begin
                            n_done  = 1'b0;
                            n_state = S_FETCH;
                        end else if (r_np == 2'd1) begin
                            n_rf[xi] = r_a;
                        end else if (r_x >= RC_W) begin
                            n_running = 1'b0;
                            n_status  = first_err(r_status, svm_pkg::ST_BAD_REG);
                        end else if (r_op == svm_pkg::OP_LOD) begin
                            if (sp_s >= SD_S - 32'sd1) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_OVERFLOW);
                            end else if (sp_s < -32'sd1) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_UNDERFLOW);
                            end else begin
                                push_en  = 1'b1;
                                push_val = r_rf[xi];
                            end
                        end else begin
                            if (sp_s < 32'sd0) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_UNDERFLOW);
                            end else if (sp_s >= SD_S) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_OVERFLOW);
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SRD;
                            end
                        end
                    end
                    svm_pkg::OP_ADD, svm_pkg::OP_SUB, svm_pkg::OP_MUL,
                    svm_pkg::OP_DIV, svm_pkg::OP_MOD, svm_pkg::OP_CMP: begin
                        if (r_np == 2'd0) begin
                            if (sp_s < 32'sd1) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_UNDERFLOW);
                            end else if (sp_s >= SD_S) begin
                                n_running = 1'b0;
                                n_status  = first_err(r_status, svm_pkg::ST_OVERFLOW);
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SRD;
                            end
                        end else if (r_np == 2'd1) begin
                            n_done  = 1'b0;
                            n_state = S_SRD;
                        end else begin
                            case (r_op)
                                svm_pkg::OP_ADD: begin
                                    push_en  = 1'b1;
                                    push_val = r_b + r_a;
                                end
                                svm_pkg::OP_SUB: begin
                                    push_en  = 1'b1;
                                    push_val = r_b - r_a;
                                end
                                svm_pkg::OP_MUL: begin
                                    push_en  = 1'b1;
                                    push_val = prod;
                                end
                                svm_pkg::OP_CMP: begin
                                    // operands are still in place above the pointer, so it is moved back by two
                                    n_fgt = $signed(r_b) > $signed(r_a);
                                    n_flt = $signed(r_b) < $signed(r_a);
                                    n_feq = (r_a == r_b);
                                    n_rf[svm_pkg::SP_INDEX] =
                                        r_rf[svm_pkg::SP_INDEX] + 32'd2;
                                end
                                default: begin
                                    if (r_a == '0) begin
                                        n_running = 1'b0;
                                        n_status  = first_err(r_status, svm_pkg::ST_DIV_ZERO);
                                    end else begin
                                        div_start = 1'b1;
                                        n_done    = 1'b0;
                                        n_state   = S_DIV;
                                    end
                                end
                            endcase
                        end
                    end
                    svm_pkg::OP_JMP, svm_pkg::OP_JEQ, svm_pkg::OP_JNE,
                    svm_pkg::OP_JGT, svm_pkg::OP_JLT: begin
                        if (r_nf == 2'd1) begin
                            n_done  = 1'b0;
                            n_state = S_FETCH;
                        end else begin
                            case (r_op)
                                svm_pkg::OP_JMP: take = 1'b1;
                                svm_pkg::OP_JEQ: take = r_feq;
                                svm_pkg::OP_JNE: take = !r_feq;
                                svm_pkg::OP_JGT: take = r_fgt;
                                default:         take = r_flt;
                            endcase
                            if (take) begin
                                if (r_x >= PD_W) begin
                                    n_running = 1'b0;
                                    n_status  = first_err(r_status, svm_pkg::ST_BAD_JUMP);
                                end else begin
                                    n_rf[svm_pkg::IP_INDEX] = r_x;
                                end
                            end
                        end
                    end
                    default: begin
                        n_running = 1'b0;
                        n_status  = first_err(r_status, svm_pkg::ST_BAD_OP);
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_en) begin
            n_rf[svm_pkg::SP_INDEX] = sp1;
            if (sp1 >= 32'sd0 && sp1 < SD_S) begin
                s_we    = 1'b1;
                s_waddr = sp1[svm_pkg::SAW-1:0];
                s_wdata = push_val;
            end
        end

        if (n_done) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_feq     <= 1'b0;
            r_fgt     <= 1'b0;
            r_flt     <= 1'b0;
            r_running <= 1'b0;
            r_pvld    <= '0;
            r_ov      <= 1'b0;
            for (int i = 0; i < svm_pkg::REGISTER_COUNT; i++) begin
                r_rf[i] <= (i == svm_pkg::SP_INDEX) ? '1 : '0;
            end
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_feq     <= n_feq;
            r_fgt     <= n_fgt;
            r_flt     <= n_flt;
            r_running <= n_running;
            r_pvld    <= n_pvld;
            r_rf      <= n_rf;
            if (r_done) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
        r_op     <= n_op;
        r_x      <= n_x;
        r_y      <= n_y;
        r_a      <= n_a;
        r_b      <= n_b;
        r_nf     <= n_nf;
        r_np     <= n_np;
        r_status <= n_status;
        r_pv     <= n_pv;
        r_pk     <= n_pk;
        r_pval   <= n_pval;
        r_paddr  <= n_paddr;
        if (r_done) begin
            r_o_pv     <= r_pv;
            r_o_pk     <= r_pk;
            r_o_pval   <= r_pval;
            r_o_run    <= r_running;
            r_o_status <= r_status;
            r_o_flags  <= {r_flt, r_fgt, r_feq};
        end
    end

    // a new item only once the previous result has moved to the output register
    assign o_ready         = (r_state == S_IDLE) && !r_done && (!r_ov || i_ready);
    assign o_valid         = r_ov;
    assign o_print_valid   = r_o_pv;
    assign o_print_kind    = r_o_pk;
    assign o_print_value   = r_o_pval;
    assign o_running       = r_o_run;
    assign o_status        = r_o_status;
    assign o_compare_flags = r_o_flags;

endmodule
